FILE: sv/shrlk_pkg.sv
`default_nettype none

package shrlk_pkg;

  // slot side: days and periods both run 1..7
  localparam int SLOT_SIDE = 7;
  // bin index width, covers up to 64 bins
  localparam int BIN_W = 6;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SEARCH
  } shrlk_state_t;

  // control broadcast to every cell
  typedef struct packed {
    logic             rec_en;
    logic [BIN_W-1:0] rec_bin;
    logic             clr_taken;
    logic             mark_en;
    logic [BIN_W-1:0] mark_bin;
  } shrlk_ctl_t;

  // search token handed from cell to cell (count travels beside it)
  typedef struct packed {
    logic             go;
    logic             valid;
    logic [BIN_W-1:0] idx;
  } shrlk_tok_t;

  // bin / 7 by compare ladder
  function automatic logic [3:0] bin_quot(input logic [BIN_W-1:0] bin);
    logic [3:0] q;
    q = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (bin >= BIN_W'(SLOT_SIDE * k)) q = 4'(k);
    end
    return q;
  endfunction

  function automatic logic [2:0] bin_day(input logic [BIN_W-1:0] bin);
    logic [3:0] q;
    q = bin_quot(bin);
    return 3'(q + 4'd1);
  endfunction

  function automatic logic [2:0] bin_period(input logic [BIN_W-1:0] bin);
    logic [3:0]       q;
    logic [BIN_W-1:0] rem;
    q   = bin_quot(bin);
    rem = bin - BIN_W'({2'b00, q} * 6'd7);
    return 3'(rem + BIN_W'(1));
  endfunction

endpackage

`default_nettype wire

FILE: sv/shrlk_cell.sv
`default_nettype none

module shrlk_cell
  import shrlk_pkg::*;
#(
  parameter int COUNT_BITS = 16,
  parameter int IDX        = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire shrlk_ctl_t            ctl,
  input  wire shrlk_tok_t            tok_in,
  input  wire logic [COUNT_BITS-1:0] cnt_in,
  output shrlk_tok_t                 tok_out,
  output logic      [COUNT_BITS-1:0] cnt_out
);

  localparam logic [BIN_W-1:0] MY_BIN = BIN_W'(IDX);

  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  taken_r, taken_nxt;
  shrlk_tok_t            tok_r, tok_nxt;
  logic [COUNT_BITS-1:0] tcnt_r, tcnt_nxt;
  logic                  better;

  always_comb begin
    count_nxt = count_r;
    if (ctl.rec_en && ctl.rec_bin == MY_BIN && count_r != '1) begin
      count_nxt = count_r + COUNT_BITS'(1);
    end
    taken_nxt = taken_r;
    if (ctl.clr_taken) begin
      taken_nxt = 1'b0;
    end else if (ctl.mark_en && ctl.mark_bin == MY_BIN) begin
      taken_nxt = 1'b1;
    end
  end

  // strict less keeps the earlier bin on a tie
  always_comb begin
    better        = !taken_r && (!tok_in.valid || count_r < cnt_in);
    tok_nxt.go    = tok_in.go;
    tok_nxt.valid = tok_in.valid || !taken_r;
    tok_nxt.idx   = better ? MY_BIN : tok_in.idx;
    tcnt_nxt      = better ? count_r : cnt_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      taken_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      count_r <= count_nxt;
      taken_r <= taken_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tcnt_r <= tcnt_nxt;
  end

  assign tok_out = tok_r;
  assign cnt_out = tcnt_r;

endmodule

`default_nettype wire

FILE: sv/shrlk_chain.sv
`default_nettype none

module shrlk_chain
  import shrlk_pkg::*;
#(
  parameter int NUM_BINS   = 49,
  parameter int COUNT_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire shrlk_ctl_t            ctl,
  input  wire shrlk_tok_t            head_tok,
  input  wire logic [COUNT_BITS-1:0] head_cnt,
  output shrlk_tok_t                 tail_tok,
  output logic      [COUNT_BITS-1:0] tail_cnt
);

  shrlk_tok_t            tok [NUM_BINS+1];
  logic [COUNT_BITS-1:0] cnt [NUM_BINS+1];

  assign tok[0] = head_tok;
  assign cnt[0] = head_cnt;

  for (genvar i = 0; i < NUM_BINS; i++) begin : g_cell
    shrlk_cell #(
      .COUNT_BITS(COUNT_BITS),
      .IDX       (i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .tok_in (tok[i]),
      .cnt_in (cnt[i]),
      .tok_out(tok[i+1]),
      .cnt_out(cnt[i+1])
    );
  end

  assign tail_tok = tok[NUM_BINS];
  assign tail_cnt = cnt[NUM_BINS];

endmodule

`default_nettype wire

FILE: sv/slot_histogram_rank_least_k_unit.sv
`default_nettype none

// Weekly slot histogram with a least-used report. A record beat (operation 0)
// leaves busy low, so while no report runs records may arrive every cycle; a
// day or period outside 1..7 is dropped. A report beat (operation 1) emits
// min(report_count, NUM_BINS) results, raising busy unless that is zero,
// ascending by count, ties to the lower day-major bin, out_last on the final
// one. Each result shows for exactly one cycle on out_strobe and cannot be
// stalled, so the receiver must take it then. The bins form a chain of cells;
// a search token walks one cell per cycle and picks the smallest unreported
// bin, so each result takes a launch state plus the chain walk, and busy
// stays high until the last result is out. The user must write report_count
// through cfg_wr_en/cfg_wr_data only while idle; the block does not check it.
module slot_histogram_rank_least_k_unit
  import shrlk_pkg::*;
#(
  parameter int NUM_BINS   = 49,
  parameter int COUNT_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // command side
  input  wire logic       start,
  output logic            busy,
  input  wire logic       in_operation,
  input  wire logic [3:0] in_day,
  input  wire logic [3:0] in_period,
  // config
  input  wire logic       cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data,
  // results
  output logic            out_strobe,
  output logic [2:0]      out_slot_day,
  output logic [2:0]      out_slot_period,
  output logic [15:0]     out_slot_count,
  output logic            out_last
);

  localparam int N_W = $clog2(NUM_BINS + 1);

  shrlk_state_t state_r, state_nxt;

  logic [5:0]     rpt_cnt_r;
  logic [N_W-1:0] remain_r, remain_nxt;

  logic accept, do_record, do_report, launch, emit, clr_taken;
  logic slot_ok;
  logic [2:0]       day_m1, per_m1;
  logic [BIN_W-1:0] rec_bin;
  logic [6:0]       rpt_req;
  logic [6:0]       rpt_len;

  shrlk_ctl_t            ctl;
  shrlk_tok_t            head_tok, tail_tok;
  logic [COUNT_BITS-1:0] tail_cnt;

  logic        ostb_r;
  logic [2:0]  oday_r, oper_r;
  logic [15:0] ocnt_r;
  logic        olast_r;

  assign accept = start && !busy;

  // slot decode
  always_comb begin
    slot_ok   = (in_day inside {[4'd1:4'd7]}) && (in_period inside {[4'd1:4'd7]});
    day_m1    = 3'(in_day - 4'd1);
    per_m1    = 3'(in_period - 4'd1);
    rec_bin   = BIN_W'({3'b000, day_m1} * 6'd7) + BIN_W'(per_m1);
    do_record = accept && in_operation == OP_RECORD && slot_ok;
    // report length, clamped to the bin count
    rpt_req   = {1'b0, rpt_cnt_r};
    rpt_len   = (rpt_req > 7'(NUM_BINS)) ? 7'(NUM_BINS) : rpt_req;
    do_report = accept && in_operation == OP_REPORT && rpt_len != 7'd0;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (do_report) state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail_tok.go) begin
          state_nxt = (remain_r == N_W'(1)) ? ST_IDLE : ST_LAUNCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy      = 1'b0;
    launch    = 1'b0;
    emit      = 1'b0;
    clr_taken = 1'b0;
    case (state_r)
      ST_IDLE: begin
        clr_taken = do_report;
      end
      ST_LAUNCH: begin
        busy   = 1'b1;
        launch = 1'b1;
      end
      ST_SEARCH: begin
        busy = 1'b1;
        emit = tail_tok.go;
      end
      default: busy = 1'b0;
    endcase
  end

  always_comb begin
    remain_nxt = remain_r;
    if (do_report) begin
      remain_nxt = N_W'(rpt_len);
    end else if (emit) begin
      remain_nxt = remain_r - N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rpt_cnt_r <= 6'd49;
      remain_r  <= '0;
      ostb_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      remain_r <= remain_nxt;
      ostb_r   <= emit;
      if (cfg_wr_en) rpt_cnt_r <= cfg_wr_data;
    end
  end

  // result beat registers
  always_ff @(posedge clk) begin
    if (emit) begin
      oday_r  <= bin_day(tail_tok.idx);
      oper_r  <= bin_period(tail_tok.idx);
      ocnt_r  <= 16'(tail_cnt);
      olast_r <= (remain_r == N_W'(1));
    end
  end

  // chain control: a launch sends an empty token into the first cell
  always_comb begin
    ctl.rec_en    = do_record;
    ctl.rec_bin   = rec_bin;
    ctl.clr_taken = clr_taken;
    ctl.mark_en   = emit;
    ctl.mark_bin  = tail_tok.idx;
    head_tok.go    = launch;
    head_tok.valid = 1'b0;
    head_tok.idx   = '0;
  end

  shrlk_chain #(
    .NUM_BINS  (NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .head_tok(head_tok),
    .head_cnt('0),
    .tail_tok(tail_tok),
    .tail_cnt(tail_cnt)
  );

  assign out_strobe      = ostb_r;
  assign out_slot_day    = oday_r;
  assign out_slot_period = oper_r;
  assign out_slot_count  = ocnt_r;
  assign out_last        = olast_r;

  // a token only leaves the chain during a search
  a_tail_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tail_tok.go |-> state_r == ST_SEARCH)
    else $error("token left chain outside search");

  // every emitted token carries a real bin
  a_tail_valid: assert property (@(posedge clk) disable iff (!rst_n)
    tail_tok.go |-> tail_tok.valid)
    else $error("search found no bin");

  // results are a chain walk apart, so never back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result beats");

  // the final beat frees the block
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> !busy)
    else $error("busy after final result");

endmodule

`default_nettype wire

FILE: tb/sv/slot_histogram_rank_least_k_unit_test.sv
`default_nettype none

module slot_histogram_rank_least_k_unit_test;
  import shrlk_pkg::*;

  localparam int NUM_BINS      = 49;
  localparam int COUNT_BITS    = 16;
  localparam int COUNT_MAX     = (1 << COUNT_BITS) - 1;
  // settle margin long enough for one more chain walk after a report result
  localparam int SETTLE_CYCLES = NUM_BINS + 11;
  // keep a wide margin even if every beat were a full 49-slot report
  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int MAX_SHOWN     = 40;

  // one ranked slot as it leaves the block
  typedef struct packed {
    logic [2:0]  day;
    logic [2:0]  period;
    logic [15:0] count;
    logic        last;
  } slot_pick_t;

  // Shadow histogram plus the queue of ranked slots still owed by the block.
  class slot_rank_board;
    logic [COUNT_BITS-1:0] hist [NUM_BINS];
    int unsigned           report_len;
    slot_pick_t            due_q [$];
    int unsigned           errors;
    int unsigned           shown;

    function new();
      foreach (hist[b]) hist[b] = '0;
      report_len = NUM_BINS;
      errors     = 0;
      shown      = 0;
    endfunction

    function void write_report_len(logic [5:0] v);
      report_len = v;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // accepted command beat: bump a bin, or rank the bins and queue the picks
    function void note_beat(logic op, logic [3:0] d, logic [3:0] p);
      int         bin;
      int         n;
      int         best;
      bit         taken [NUM_BINS];
      slot_pick_t pick;
      if (op == OP_RECORD) begin
        if (d < 1 || d > SLOT_SIDE || p < 1 || p > SLOT_SIDE) return;
        bin = (int'(d) - 1) * SLOT_SIDE + (int'(p) - 1);
        if (bin >= NUM_BINS) return;
        if (hist[bin] != COUNT_MAX) hist[bin] = hist[bin] + 1'b1;
        return;
      end
      n = (report_len > NUM_BINS) ? NUM_BINS : report_len;
      foreach (taken[b]) taken[b] = 1'b0;
      // repeated min search, strict less-than keeps the lower bin on ties
      for (int k = 0; k < n; k++) begin
        best = -1;
        for (int b = 0; b < NUM_BINS; b++) begin
          if (!taken[b] && (best < 0 || hist[b] < hist[best])) best = b;
        end
        taken[best] = 1'b1;
        pick.day    = 3'(best / SLOT_SIDE + 1);
        pick.period = 3'(best % SLOT_SIDE + 1);
        pick.count  = 16'(hist[best]);
        pick.last   = (k == n - 1);
        due_q.push_back(pick);
      end
    endfunction

    function void check_result(slot_pick_t got);
      slot_pick_t want;
      if (due_q.size() == 0) begin
        errors++;
        if (shown++ < MAX_SHOWN)
          $display("%0t: unexpected slot: got day %0d period %0d count %0d last %0d",
                   $time, got.day, got.period, got.count, got.last);
        return;
      end
      want = due_q.pop_front();
      if (got.day !== want.day || got.period !== want.period ||
          got.count !== want.count || got.last !== want.last) begin
        errors++;
        if (shown++ < MAX_SHOWN)
          $display({"%0t: slot mismatch: expected day %0d period %0d count %0d last %0d,",
                    " got day %0d period %0d count %0d last %0d"},
                   $time, want.day, want.period, want.count, want.last,
                   got.day, got.period, got.count, got.last);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [3:0]  in_day;
  logic [3:0]  in_period;
  logic        cfg_wr_en;
  logic [5:0]  cfg_wr_data;
  logic        out_strobe;
  logic [2:0]  out_slot_day;
  logic [2:0]  out_slot_period;
  logic [15:0] out_slot_count;
  logic        out_last;

  slot_rank_board board;
  int unsigned    cycle_count = 0;
  int             burst_left;
  bit             gaps_on;

  slot_histogram_rank_least_k_unit #(
    .NUM_BINS  (NUM_BINS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_day         (in_day),
    .in_period      (in_period),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_strobe     (out_strobe),
    .out_slot_day   (out_slot_day),
    .out_slot_period(out_slot_period),
    .out_slot_count (out_slot_count),
    .out_last       (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Results cannot be held off: every strobe is a beat taken at this edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      board.check_result(slot_pick_t'{out_slot_day, out_slot_period,
                                      out_slot_count, out_last});
  end

  // watchdog
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("** slot_histogram_rank_least_k_unit: FAILED **");
    $finish;
  end

  // Drive at the falling edge, then hold start until an edge sees busy low.
  // The shadow model takes the beat at that same edge.
  task automatic send_beat(input logic op, input logic [3:0] d, input logic [3:0] p);
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_day       <= d;
    in_period    <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_beat(op, d, p);
  endtask

  // an idle gap with start low; payload wiggles so a dropped start is noticed
  task automatic rest_cycle();
    @(negedge clk);
    start        <= 1'b0;
    in_operation <= 1'($urandom);
    in_day       <= 4'($urandom);
    in_period    <= 4'($urandom);
  endtask

  // bursty sender: random burst lengths, random gaps between bursts when gaps_on
  task automatic pace_beat(input logic op, input logic [3:0] d, input logic [3:0] p);
    if (burst_left <= 0) begin
      if (gaps_on) repeat ($urandom_range(1, 6)) rest_cycle();
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_beat(op, d, p);
  endtask

  // stop sending, wait out every owed slot, then let any silent walk finish
  // (records and empty reports leave nothing to wait on)
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register writes only happen on an idle block
  task automatic set_report_len(input logic [5:0] v);
    drain();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    board.write_report_len(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 6'($urandom);
  endtask

  // Mostly well-formed records, skewed toward a corner of the week so counts
  // spread out and ties stay common; some reports and some raw noise.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)
      pace_beat(OP_REPORT, 4'($urandom), 4'($urandom));
    else if (r < 20)
      pace_beat(OP_RECORD, 4'($urandom), 4'($urandom));
    else if (r < 55)
      pace_beat(OP_RECORD, 4'($urandom_range(1, 3)), 4'($urandom_range(5, 7)));
    else
      pace_beat(OP_RECORD, 4'($urandom_range(1, 7)), 4'($urandom_range(1, 7)));
  endtask

  initial begin
    logic [5:0] len;
    board        = new();
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_RECORD;
    in_day       = 4'd0;
    in_period    = 4'd0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 6'd0;
    burst_left   = 0;
    gaps_on      = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty histogram at the reset length: all 49 slots in bin order
    pace_beat(OP_REPORT, 4'd0, 4'd0);
    // corners of the week and its centre, one slot twice
    pace_beat(OP_RECORD, 4'd1, 4'd1);
    pace_beat(OP_RECORD, 4'd1, 4'd1);
    pace_beat(OP_RECORD, 4'd7, 4'd7);
    pace_beat(OP_RECORD, 4'd1, 4'd7);
    pace_beat(OP_RECORD, 4'd7, 4'd1);
    pace_beat(OP_RECORD, 4'd4, 4'd4);
    // day or period outside 1..7: dropped silently
    pace_beat(OP_RECORD, 4'd0, 4'd3);
    pace_beat(OP_RECORD, 4'd8, 4'd3);
    pace_beat(OP_RECORD, 4'd3, 4'd0);
    pace_beat(OP_RECORD, 4'd3, 4'd15);
    pace_beat(OP_RECORD, 4'd15, 4'd15);
    pace_beat(OP_RECORD, 4'd0, 4'd0);
    // sender holds off until the block has nothing left to say
    drain();
    pace_beat(OP_REPORT, 4'hF, 4'hF);
    // zero length: report emits nothing
    set_report_len(6'd0);
    pace_beat(OP_REPORT, 4'd5, 4'd9);
    // register maximum, clamped to all bins
    set_report_len(6'd63);
    pace_beat(OP_REPORT, 4'd0, 4'd0);
    // single result, last set on it
    set_report_len(6'd1);
    pace_beat(OP_REPORT, 4'd7, 4'd7);
    // just past the bin count
    set_report_len(6'd50);
    pace_beat(OP_REPORT, 4'd3, 4'd3);

    // random phases across a spread of report lengths
    for (int ph = 0; ph < 11; ph++) begin
      case (ph)
        0: len = 6'd49;
        1: len = 6'd0;
        2: len = 6'd1;
        3: len = 6'd63;
        4: len = 6'd48;
        5: len = 6'd2;
        6: len = 6'd50;
        default: len = 6'($urandom_range(0, 63));
      endcase
      set_report_len(len);
      gaps_on = (ph % 3 != 1);
      repeat (28) random_item();
    end

    // closing reports at full and short length
    set_report_len(6'd49);
    gaps_on = 1'b1;
    pace_beat(OP_RECORD, 4'd2, 4'd6);
    pace_beat(OP_REPORT, 4'd0, 4'd0);
    set_report_len(6'd2);
    pace_beat(OP_REPORT, 4'd6, 4'd2);

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** slot_histogram_rank_least_k_unit: PASSED **");
    end else begin
      $display("** slot_histogram_rank_least_k_unit: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: slot_histogram_rank_least_k_unit.f
sv/shrlk_pkg.sv
sv/shrlk_cell.sv
sv/shrlk_chain.sv
sv/slot_histogram_rank_least_k_unit.sv
tb/sv/slot_histogram_rank_least_k_unit_test.sv
